// ===== hdl/cpb_pkg.sv =====
package cpb_pkg;

  localparam logic [7:0] AlphaFull  = 8'hFF;
  localparam logic [7:0] AlphaNone  = 8'h00;
  localparam logic [7:0] RoundBias  = 8'd127;
  localparam int unsigned NumChan   = 3;
  localparam int unsigned CfgIdxW   = 2;

  typedef enum logic [CfgIdxW-1:0] {
    REG_RED   = 2'd0,
    REG_GREEN = 2'd1,
    REG_BLUE  = 2'd2,
    REG_ALPHA = 2'd3
  } cpb_reg_e;

  // What the final stage does with the pixel.
  typedef enum logic [1:0] {
    KIND_KEEP,
    KIND_OPAQUE_GLYPH,
    KIND_OPAQUE_FILL,
    KIND_BLEND
  } cpb_kind_e;

  typedef struct packed {
    logic [7:0] r;
    logic [7:0] g;
    logic [7:0] b;
  } cpb_rgb_t;

  // Item between the alpha unit and the mixing unit.
  typedef struct packed {
    logic        op;
    logic [7:0]  ca;
    logic [7:0]  alpha;
    cpb_kind_e   kind;
    logic [31:0] dest;
  } cpb_mid_t;

  // Exact floor(x / 255) for x below 65280, by the reciprocal trick.
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] t;
    t = {1'b0, x} + {9'd0, x[15:8]} + 17'd1;
    return t[15:8];
  endfunction

endpackage

// ===== hdl/cpb_if.sv =====
interface cpb_req_if;
  logic        valid;
  logic        ready;
  logic        opcode;
  logic [7:0]  coverage;
  logic [31:0] dest_pixel;

  modport source (output valid, output opcode, output coverage, output dest_pixel,
                  input ready);
  modport sink (input valid, input opcode, input coverage, input dest_pixel,
                output ready);
endinterface

interface cpb_res_if;
  logic        valid;
  logic        ready;
  logic [31:0] pixel_out;
  logic        write_enable;

  modport source (output valid, output pixel_out, output write_enable, input ready);
  modport sink (input valid, input pixel_out, input write_enable, output ready);
endinterface

// ===== hdl/colour_over_pixel_blend.sv =====
// Blends the configured drawing colour over one RGBA pixel per request (byte 0 red,
// byte 3 alpha). Glyph requests (opcode 0) scale the colour alpha by the coverage byte
// and round; fill requests (opcode 1) use the colour alpha and truncate. Every request
// gives exactly one result with the new pixel and a write enable, which is low when the
// pixel stays as it was. The block takes one request per clock unless the result
// channel holds it back, and has four register stages: alpha product, effective
// alpha, per-channel weighted sums, and the final divide by 255 into the output
// register. Back-pressure on the result channel holds each full stage, while empty
// stages still fill. Write the colour registers only while no request is in flight.
module colour_over_pixel_blend
  import cpb_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CfgIdxW-1:0] cfg_idx_i,
  input  logic [7:0]         cfg_data_i,
  cpb_req_if.sink            req_i,
  cpb_res_if.source          res_o
);

  // Drawing colour registers.
  cpb_rgb_t   rgb_q;
  logic [7:0] ca_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rgb_q <= '0;
      ca_q  <= '0;
    end else if (cfg_we_i) begin
      unique case (cpb_reg_e'(cfg_idx_i))
        REG_RED:   rgb_q.r <= cfg_data_i;
        REG_GREEN: rgb_q.g <= cfg_data_i;
        REG_BLUE:  rgb_q.b <= cfg_data_i;
        REG_ALPHA: ca_q    <= cfg_data_i;
        default:   ca_q    <= ca_q;
      endcase
    end
  end

  logic     mid_valid;
  logic     mid_ready;
  cpb_mid_t mid;

  // The first two stages work out the effective alpha and what kind of write follows.
  cpb_alpha u_alpha (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ca_i        (ca_q),
    .req_i       (req_i),
    .mid_valid_o (mid_valid),
    .mid_ready_i (mid_ready),
    .mid_o       (mid)
  );

  // The last two stages mix each channel and hold the result until it is taken.
  cpb_mix u_mix (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rgb_i       (rgb_q),
    .mid_valid_i (mid_valid),
    .mid_ready_o (mid_ready),
    .mid_i       (mid),
    .res_o       (res_o)
  );

`ifndef SYNTH
  // With the output register empty, no stage can be holding the pipe back.
  a_ready_when_out_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !res_o.valid |-> req_i.ready)
    else $error("request refused while the output register is empty");

  // A glyph with a translucent colour can never reach full effective alpha.
  a_glyph_alpha_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_valid && !mid.op && mid.ca != AlphaFull |-> mid.alpha != AlphaFull)
    else $error("glyph effective alpha reached full with a translucent colour");

  // Fill requests never take the glyph opaque path, which replaces byte 3.
  a_fill_keeps_alpha_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mid_valid && mid.op |-> mid.kind != KIND_OPAQUE_GLYPH)
    else $error("fill request routed to the glyph opaque write");
`endif

endmodule

// ===== hdl/cpb_alpha.sv =====
module cpb_alpha
  import cpb_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [7:0] ca_i,
  cpb_req_if.sink    req_i,
  output logic       mid_valid_o,
  input  logic       mid_ready_i,
  output cpb_mid_t   mid_o
);

  typedef struct packed {
    logic        op;
    logic [7:0]  cov;
    logic [7:0]  ca;
    logic [15:0] prod;
    logic [31:0] dest;
  } s1_t;

  logic     s1_v_q;
  s1_t      s1_q, s1_d;
  logic     s2_v_q;
  cpb_mid_t s2_q, s2_d;
  logic     s1_rdy, s2_rdy;

  assign s2_rdy      = !s2_v_q || mid_ready_i;
  assign s1_rdy      = !s1_v_q || s2_rdy;
  assign req_i.ready = s1_rdy;

  // Stage 1: coverage times colour alpha, with the rounding bias.
  always_comb begin
    s1_d.op   = req_i.opcode;
    s1_d.cov  = req_i.coverage;
    s1_d.ca   = ca_i;
    s1_d.prod = {8'd0, ca_i} * {8'd0, req_i.coverage} + {8'd0, RoundBias};
    s1_d.dest = req_i.dest_pixel;
  end

  // Stage 2: effective alpha and the kind of write.
  always_comb begin
    s2_d.op   = s1_q.op;
    s2_d.ca   = s1_q.ca;
    s2_d.dest = s1_q.dest;
    if (s1_q.op) begin
      s2_d.alpha = s1_q.ca;
    end else if (s1_q.ca == AlphaFull) begin
      s2_d.alpha = s1_q.cov;
    end else begin
      s2_d.alpha = div255(s1_q.prod);
    end
    if (s2_d.alpha == AlphaNone) begin
      s2_d.kind = KIND_KEEP;
    end else if (s2_d.alpha == AlphaFull) begin
      s2_d.kind = s1_q.op ? KIND_OPAQUE_FILL : KIND_OPAQUE_GLYPH;
    end else begin
      s2_d.kind = KIND_BLEND;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
      s2_v_q <= 1'b0;
    end else begin
      if (s1_rdy) s1_v_q <= req_i.valid;
      if (s2_rdy) s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && req_i.valid) s1_q <= s1_d;
    if (s2_rdy && s1_v_q) s2_q <= s2_d;
  end

  assign mid_valid_o = s2_v_q;
  assign mid_o       = s2_q;

endmodule

// ===== hdl/cpb_mix.sv =====
module cpb_mix
  import cpb_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  cpb_rgb_t rgb_i,
  input  logic     mid_valid_i,
  output logic     mid_ready_o,
  input  cpb_mid_t mid_i,
  cpb_res_if.source res_o
);

  typedef struct packed {
    cpb_kind_e   kind;
    logic [7:0]  ca;
    logic [31:0] dest;
    logic [NumChan-1:0][15:0] sum;
  } s3_t;

  logic        s3_v_q;
  s3_t         s3_q, s3_d;
  logic        s4_v_q;
  logic [31:0] pix_q, pix_d;
  logic        we_q, we_d;
  logic        s3_rdy, s4_rdy;
  logic [NumChan-1:0][7:0] col;
  logic [NumChan-1:0][7:0] quo;

  assign col    = {rgb_i.b, rgb_i.g, rgb_i.r};
  assign s4_rdy = !s4_v_q || res_o.ready;
  assign s3_rdy = !s3_v_q || s4_rdy;
  assign mid_ready_o = s3_rdy;

  // Stage 3: weighted sum of destination and colour for each channel.
  always_comb begin
    s3_d.kind = mid_i.kind;
    s3_d.ca   = mid_i.ca;
    s3_d.dest = mid_i.dest;
    for (int i = 0; i < NumChan; i++) begin
      s3_d.sum[i] = {8'd0, mid_i.dest[8*i +: 8]} * {8'd0, AlphaFull - mid_i.alpha}
                  + {8'd0, col[i]} * {8'd0, mid_i.alpha}
                  + (mid_i.op ? 16'd0 : {8'd0, RoundBias});
    end
  end

  // Stage 4: divide by 255 and assemble the pixel.
  always_comb begin
    for (int i = 0; i < NumChan; i++) begin
      quo[i] = div255(s3_q.sum[i]);
    end
    unique case (s3_q.kind)
      KIND_KEEP: begin
        pix_d = s3_q.dest;
        we_d  = 1'b0;
      end
      KIND_OPAQUE_GLYPH: begin
        pix_d = {s3_q.ca, col[2], col[1], col[0]};
        we_d  = 1'b1;
      end
      KIND_OPAQUE_FILL: begin
        pix_d = {s3_q.dest[31:24], col[2], col[1], col[0]};
        we_d  = 1'b1;
      end
      default: begin
        pix_d = {s3_q.dest[31:24], quo[2], quo[1], quo[0]};
        we_d  = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
      s4_v_q <= 1'b0;
    end else begin
      if (s3_rdy) s3_v_q <= mid_valid_i;
      if (s4_rdy) s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_rdy && mid_valid_i) s3_q <= s3_d;
    if (s4_rdy && s3_v_q) begin
      pix_q <= pix_d;
      we_q  <= we_d;
    end
  end

  assign res_o.valid        = s4_v_q;
  assign res_o.pixel_out    = pix_q;
  assign res_o.write_enable = we_q;

endmodule
